FILE: rtl/ranked_count_table_assert.svh
// Assertion macros used by the checker file of the ranked count table.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef RANKED_COUNT_TABLE_ASSERT_SVH
`define RANKED_COUNT_TABLE_ASSERT_SVH

// The consequent is checked in the same cycle as the antecedent.
`define RCT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define RCT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rct_pkg.sv
// Shared types, constants and command codes of the ranked count table.
// No dependencies; every other file but the assertion header imports this package.
package rct_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);

  localparam logic [2:0] CMD_ADD        = 3'd0;
  localparam logic [2:0] CMD_CLEAR      = 3'd1;
  localparam logic [2:0] CMD_SORT       = 3'd2;
  localparam logic [2:0] CMD_NEXT       = 3'd3;
  localparam logic [2:0] CMD_REWIND     = 3'd4;
  localparam logic [2:0] CMD_READ_COUNT = 3'd5;
  localparam logic [2:0] CMD_READ_LABEL = 3'd6;

  localparam logic signed [31:0] INT_TOP    = 32'sh7fff_ffff;
  localparam logic signed [31:0] INT_BOTTOM = 32'sh8000_0000;
  localparam logic signed [31:0] ITER_START = -32'sd1;
  localparam logic [31:0]        TOTAL_TOP  = 32'hffff_ffff;

  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(TABLE_SIZE - 1);

  typedef logic [IDX_W-1:0] rct_addr_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [15:0]        entry_index;
    logic signed [31:0] add_amount;
  } request_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               accepted;
    logic [31:0]        saved_total;
    logic [31:0]        ignored_total;
  } result_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_KEY,
    ST_SCAN,
    ST_PLACE
  } rct_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;    // capture the request and read its entry
    logic commit;  // finish the request and load the result register
    logic fill;    // reset pass: write label = position, count = 0
    logic zero;    // clear pass: write count = 0
    logic key;     // sort: capture the entry being inserted
    logic shift;   // sort: move the compared entry down into the hole
    logic place;   // sort: drop the captured entry into the hole
  } rct_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] cmd;
    logic       out_free;
    logic       pos_last;
    logic       less;
    logic       hole_one;
  } rct_status_t;

endpackage

FILE: rtl/rct_controller.sv
// Controller state machine of the ranked count table.
// Depends on rct_pkg for the state, command and status types.
module rct_controller import rct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  rct_status_t status,
  output logic        in_stall,
  output rct_ctrl_t   ctrl
);

  rct_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (status.pos_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.out_free) begin
          if (status.cmd == CMD_CLEAR) begin
            state_next = ST_CLEAR;
          end else if (status.cmd == CMD_SORT) begin
            state_next = ST_KEY;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_CLEAR: begin
        if (status.pos_last) state_next = ST_IDLE;
      end
      ST_KEY: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.less) begin
          if (status.hole_one) state_next = ST_PLACE;
        end else begin
          state_next = status.pos_last ? ST_IDLE : ST_KEY;
        end
      end
      ST_PLACE: begin
        state_next = status.pos_last ? ST_IDLE : ST_KEY;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_INIT:  ctrl.fill = 1'b1;
      ST_IDLE: begin
        in_stall  = 1'b0;
        ctrl.take = in_valid;
      end
      ST_EXEC:  ctrl.commit = status.out_free;
      ST_CLEAR: ctrl.zero = 1'b1;
      ST_KEY:   ctrl.key = 1'b1;
      ST_SCAN: begin
        ctrl.shift = status.less;
        ctrl.place = !status.less;
      end
      ST_PLACE: ctrl.place = 1'b1;
      default: begin
        ctrl     = '0;
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/rct_datapath.sv
// Datapath of the ranked count table: label and count memories, request
// registers, iterator, totals, sort registers and the result register.
// Depends on rct_pkg; driven by rct_controller.
module rct_datapath import rct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  request_t    req,
  input  rct_ctrl_t   ctrl,
  input  logic        out_stall,
  output rct_status_t status,
  output logic        out_valid,
  output result_t     out_data
);

  logic [IDX_W-1:0] lab_mem [TABLE_SIZE];
  logic [31:0]      cnt_mem [TABLE_SIZE];

  logic [IDX_W-1:0]   rd_lab;
  logic signed [31:0] rd_cnt;

  logic [2:0]         req_cmd;
  rct_addr_t          req_addr;
  logic               req_hit;
  logic signed [31:0] req_amount;

  logic signed [31:0] iter;
  logic [31:0]        saved, ignored;
  rct_addr_t          pos, hole;
  logic [IDX_W-1:0]   key_lab;
  logic signed [31:0] key_cnt;

  logic signed [31:0] iter_adv;
  logic               adv_hit;
  logic               idx_hit;
  logic signed [32:0] sum;
  logic signed [31:0] sum_sat;
  logic [31:0]        saved_next, ignored_next;
  result_t            res;

  rct_addr_t          rd_addr, wr_addr;
  logic               wr_lab_en, wr_cnt_en;
  logic [IDX_W-1:0]   wr_lab_data;
  logic [31:0]        wr_cnt_data;

  assign iter_adv = (iter != INT_TOP) ? iter + 32'sd1 : iter;
  assign adv_hit  = iter_adv < 32'sd0 + $signed(32'(TABLE_SIZE));
  assign idx_hit  = 32'(req.entry_index) < 32'(TABLE_SIZE);

  assign sum = {rd_cnt[31], rd_cnt} + {req_amount[31], req_amount};
  always_comb begin
    if (sum[32] != sum[31]) begin
      sum_sat = sum[32] ? INT_BOTTOM : INT_TOP;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  always_comb begin
    saved_next   = saved;
    ignored_next = ignored;
    if (req_cmd == CMD_ADD) begin
      if (req_hit) begin
        if (saved != TOTAL_TOP) saved_next = saved + 32'd1;
      end else begin
        if (ignored != TOTAL_TOP) ignored_next = ignored + 32'd1;
      end
    end
  end

  always_comb begin
    res               = '0;
    res.saved_total   = saved_next;
    res.ignored_total = ignored_next;
    unique case (req_cmd)
      CMD_ADD: res.accepted = req_hit;
      CMD_NEXT: begin
        res.accepted     = req_hit;
        res.result_value = req_hit ? $signed(32'(rd_lab)) : iter_adv;
      end
      CMD_READ_COUNT: begin
        res.accepted     = req_hit;
        res.result_value = req_hit ? rd_cnt : 32'sd0;
      end
      CMD_READ_LABEL: begin
        res.accepted     = req_hit;
        res.result_value = req_hit ? $signed(32'(rd_lab)) : 32'sd0;
      end
      default: res.accepted = 1'b0;
    endcase
  end

  // Memory port selection.
  always_comb begin
    rd_addr     = req_addr;
    wr_addr     = pos;
    wr_lab_en   = 1'b0;
    wr_cnt_en   = 1'b0;
    wr_lab_data = pos;
    wr_cnt_data = '0;
    if (ctrl.take) begin
      rd_addr = (req.command == CMD_NEXT) ? iter_adv[IDX_W-1:0]
                                          : req.entry_index[IDX_W-1:0];
    end
    if (ctrl.commit) begin
      if (req_cmd == CMD_ADD && req_hit) begin
        wr_cnt_en   = 1'b1;
        wr_addr     = req_addr;
        wr_cnt_data = sum_sat;
      end
      if (req_cmd == CMD_SORT) rd_addr = IDX_W'(1);
    end
    if (ctrl.fill) begin
      wr_lab_en = 1'b1;
      wr_cnt_en = 1'b1;
    end
    if (ctrl.zero) wr_cnt_en = 1'b1;
    if (ctrl.key) rd_addr = pos - IDX_W'(1);
    if (ctrl.shift) begin
      wr_lab_en   = 1'b1;
      wr_cnt_en   = 1'b1;
      wr_addr     = hole;
      wr_lab_data = rd_lab;
      wr_cnt_data = rd_cnt;
      rd_addr     = hole - IDX_W'(2);
    end
    if (ctrl.place) begin
      wr_lab_en   = 1'b1;
      wr_cnt_en   = 1'b1;
      wr_addr     = hole;
      wr_lab_data = key_lab;
      wr_cnt_data = key_cnt;
      if (pos != LAST_POS) rd_addr = pos + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_lab_en) lab_mem[wr_addr] <= wr_lab_data;
    rd_lab <= lab_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_cnt_en) cnt_mem[wr_addr] <= wr_cnt_data;
    rd_cnt <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      req_cmd    <= req.command;
      req_amount <= req.add_amount;
      req_addr   <= (req.command == CMD_NEXT) ? iter_adv[IDX_W-1:0]
                                              : req.entry_index[IDX_W-1:0];
      req_hit    <= (req.command == CMD_NEXT) ? adv_hit : idx_hit;
    end
    if (ctrl.key) begin
      key_lab <= rd_lab;
      key_cnt <= rd_cnt;
      hole    <= pos;
    end
    if (ctrl.shift) hole <= hole - IDX_W'(1);
    if (ctrl.commit) out_data <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iter      <= ITER_START;
      saved     <= '0;
      ignored   <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.commit) begin
        saved   <= saved_next;
        ignored <= ignored_next;
        if (req_cmd == CMD_NEXT) iter <= iter_adv;
        if (req_cmd == CMD_REWIND) iter <= ITER_START;
        if (req_cmd == CMD_CLEAR) pos <= '0;
        if (req_cmd == CMD_SORT) pos <= IDX_W'(1);
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (ctrl.fill || ctrl.zero) begin
        pos <= (pos == LAST_POS) ? '0 : pos + IDX_W'(1);
      end
      if (ctrl.place && pos != LAST_POS) pos <= pos + IDX_W'(1);
    end
  end

  assign status.cmd      = req_cmd;
  assign status.out_free = !out_valid || !out_stall;
  assign status.pos_last = pos == LAST_POS;
  assign status.less     = rd_cnt < key_cnt;
  assign status.hole_one = hole == IDX_W'(1);

endmodule

FILE: rtl/ranked_count_table.sv
//  Channel   Direction  Handshake                      Payload
//  request   in         request_valid / request_stall  request_t (command, index, amount)
//  result    out        result_valid  / result_stall   result_t (value, accepted, totals)
//
//  Add, next, rewind, both reads and the unused code take an accepting step, which reads
//  the memories, and a finishing step, which loads the result register once a stalled
//  result has gone. Clear adds a pass over the count memory. Sort is an insertion sort
//  that adds, for each position after the first, a key step, a scan step for every
//  entry it passes and a step that places the entry. After reset a pass loads labels
//  and zeroes counts under request_stall; a stalled result holds.
//
// Top level of the ranked count table: joins the controller and the datapath.
// Depends on rct_pkg, rct_controller and rct_datapath.
module ranked_count_table import rct_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     request_valid,
  output logic     request_stall,
  input  request_t request,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result
);

  // The controller sees only status from the datapath and answers with a
  // command word each cycle; all storage and arithmetic sit in the datapath.
  rct_ctrl_t   ctrl;
  rct_status_t status;

  rct_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request_valid),
    .status   (status),
    .in_stall (request_stall),
    .ctrl     (ctrl)
  );

  // The result register in the datapath parts the two channels, so a finished
  // result may wait for the consumer while the block returns to idle. A result
  // that is still stalled keeps the next request in its finishing cycle, so no
  // result is ever lost or repeated.
  rct_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (request),
    .ctrl      (ctrl),
    .out_stall (result_stall),
    .status    (status),
    .out_valid (result_valid),
    .out_data  (result)
  );

endmodule

FILE: rtl/rct_checker.sv
// Port-level checker of the ranked count table, bound to the top level.
// Depends on rct_pkg and ranked_count_table_assert.svh.
`include "ranked_count_table_assert.svh"

module rct_checker import rct_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     request_valid,
  input logic     request_stall,
  input request_t request,
  input logic     result_valid,
  input logic     result_stall,
  input result_t  result
);

  logic take;
  logic take_idle;
  logic quiet_cmd;
  logic add_out;
  logic refused;
  logic zero_refused;
  logic res_held;

  assign take         = request_valid && !request_stall;
  assign take_idle    = take && !result_valid;
  assign quiet_cmd    = request.command == CMD_CLEAR || request.command == CMD_SORT ||
                        request.command == CMD_REWIND;
  assign add_out      = request.command == CMD_ADD &&
                        32'(request.entry_index) >= 32'(TABLE_SIZE);
  assign refused      = result_valid && !result.accepted;
  assign zero_refused = refused && result.result_value == 32'sd0;
  assign res_held     = result_valid && result_stall;

  // Only one request is in flight at a time.
  `RCT_ASSERT_NEXT(one_in_flight, take, request_stall, "request taken while busy")
  // With the result channel empty, a taken request is finished without a stall and its result follows.
  `RCT_ASSERT_NOW(result_latency, take_idle, ##2 result_valid, "result late")
  // Clear, sort and rewind give a zero value that is not marked accepted.
  `RCT_ASSERT_NOW(quiet_result, take_idle && quiet_cmd, ##2 zero_refused, "bad quiet result")
  // A stalled result holds.
  `RCT_ASSERT_NEXT(result_hold, res_held, result_valid && $stable(result), "result changed")
  // An add outside the table is never accepted.
  `RCT_ASSERT_NOW(add_outside, take_idle && add_out, ##2 refused, "out of range add accepted")

endmodule

bind ranked_count_table rct_checker u_rct_checker (
  .clk           (clk),
  .rst           (rst),
  .request_valid (request_valid),
  .request_stall (request_stall),
  .request       (request),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .result        (result)
);

FILE: verif/tb_ranked_count_table.sv
// Self-checking testbench for the ranked count table: directed rows, then random traffic.
// Depends on rct_pkg and ranked_count_table from the rtl folder; needs nothing else.
`timescale 1ns / 1ps

module tb_ranked_count_table;
  import rct_pkg::*;

  // The command field is three bits wide, so code seven exists but means nothing.
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  // A sort of a badly ordered table is by far the slowest request; one directed
  // sort and at most a dozen random ones are issued.  Every other request is much
  // shorter even under heavy stalling, so this bound sits several times
  // above the slowest good run.
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int SORT_BUDGET  = 12;
  localparam int PHASE_ITEMS  = 30;
  localparam int SETTLE_TICKS = 20;

  typedef struct {
    request_t    req;
    bit          typed;  // the row carries its own expected result
    result_t     want;
  } stim_row_t;

  typedef struct {
    result_t     res;
    int unsigned num;
  } expected_t;

  logic     clk;
  logic     rst           = 1'b1;
  logic     request_valid = 1'b0;
  logic     request_stall;
  request_t request       = '0;
  logic     result_valid;
  logic     result_stall  = 1'b0;
  result_t  result;

  ranked_count_table dut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  // Our own copy of the table, the iterator and the two totals.
  logic [IDX_W-1:0] label_copy [TABLE_SIZE];
  int               count_copy [TABLE_SIZE];
  longint           iter_pos;
  logic [31:0]      saved_cnt;
  logic [31:0]      ignored_cnt;

  expected_t   pending_results [$];
  stim_row_t   directed_rows [$];
  int unsigned item_num    = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int          idle_pct    = 0;
  int          stall_pct   = 0;
  int          sorts_left  = SORT_BUDGET;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // The result side stalls independently of everything else, at the rate of the phase.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Works out what the block should return for one accepted request and moves our
  // copy of the state on accordingly.
  function automatic result_t apply_command(request_t r);
    result_t          o;
    logic             in_range;
    longint           sum;
    int               key_count;
    logic [IDX_W-1:0] key_label;
    int               i;
    int               j;
    o = '0;
    in_range = (int'(r.entry_index) < TABLE_SIZE);
    case (r.command)
      CMD_ADD: begin
        if (in_range) begin
          sum = longint'(count_copy[int'(r.entry_index)]) + longint'(r.add_amount);
          if (sum > longint'(INT_TOP)) sum = longint'(INT_TOP);
          if (sum < longint'(INT_BOTTOM)) sum = longint'(INT_BOTTOM);
          count_copy[int'(r.entry_index)] = int'(sum);
          if (saved_cnt != TOTAL_TOP) saved_cnt = saved_cnt + 1;
          o.accepted = 1'b1;
        end else begin
          if (ignored_cnt != TOTAL_TOP) ignored_cnt = ignored_cnt + 1;
        end
      end
      CMD_CLEAR: begin
        for (i = 0; i < TABLE_SIZE; i++) count_copy[i] = 0;
      end
      CMD_SORT: begin
        // Insertion sort, descending; the strict compare keeps equal counts in order.
        for (i = 1; i < TABLE_SIZE; i++) begin
          key_count = count_copy[i];
          key_label = label_copy[i];
          j = i - 1;
          while (j >= 0 && count_copy[j] < key_count) begin
            count_copy[j + 1] = count_copy[j];
            label_copy[j + 1] = label_copy[j];
            j--;
          end
          count_copy[j + 1] = key_count;
          label_copy[j + 1] = key_label;
        end
      end
      CMD_NEXT: begin
        if (iter_pos < longint'(INT_TOP)) iter_pos++;
        if (iter_pos >= 0 && iter_pos < TABLE_SIZE) begin
          o.result_value = 32'(label_copy[int'(iter_pos)]);
          o.accepted     = 1'b1;
        end else begin
          o.result_value = iter_pos[31:0];
        end
      end
      CMD_REWIND: begin
        iter_pos = -1;
      end
      CMD_READ_COUNT: begin
        if (in_range) begin
          o.result_value = count_copy[int'(r.entry_index)];
          o.accepted     = 1'b1;
        end
      end
      CMD_READ_LABEL: begin
        if (in_range) begin
          o.result_value = 32'(label_copy[int'(r.entry_index)]);
          o.accepted     = 1'b1;
        end
      end
      default: begin
      end
    endcase
    o.saved_total   = saved_cnt;
    o.ignored_total = ignored_cnt;
    return o;
  endfunction

  // Appends one row to the directed list; for untyped rows the last four are unused.
  function automatic void add_row(logic [2:0] cmd, logic [15:0] idx, logic signed [31:0] amt,
                                  bit typed, logic signed [31:0] value, logic acc,
                                  logic [31:0] saved, logic [31:0] ignored);
    stim_row_t row;
    row.req.command          = cmd;
    row.req.entry_index      = idx;
    row.req.add_amount       = amt;
    row.typed                = typed;
    row.want.result_value    = value;
    row.want.accepted        = acc;
    row.want.saved_total     = saved;
    row.want.ignored_total   = ignored;
    directed_rows = {directed_rows, row};
  endfunction

  // Random request: mostly adds and reads on a few low positions so that counts collide
  // and sorts have ties to keep, with edge positions, wide amounts and rare sorts mixed in.
  function automatic request_t random_request();
    request_t r;
    int       roll;
    roll = $urandom_range(99);
    if (roll < 40)       r.command = CMD_ADD;
    else if (roll < 42)  r.command = CMD_CLEAR;
    else if (roll < 45)  r.command = CMD_SORT;
    else if (roll < 60)  r.command = CMD_NEXT;
    else if (roll < 62)  r.command = CMD_REWIND;
    else if (roll < 80)  r.command = CMD_READ_COUNT;
    else if (roll < 97)  r.command = CMD_READ_LABEL;
    else                 r.command = CMD_UNUSED;
    if (r.command == CMD_SORT) begin
      if (sorts_left > 0) sorts_left--;
      else r.command = CMD_READ_COUNT;
    end
    roll = $urandom_range(99);
    if (roll < 50)       r.entry_index = 16'($urandom_range(15));
    else if (roll < 80)  r.entry_index = 16'($urandom_range(TABLE_SIZE - 1));
    else if (roll < 85)  r.entry_index = 16'(TABLE_SIZE - 1);
    else if (roll < 90)  r.entry_index = 16'(TABLE_SIZE);
    else                 r.entry_index = 16'($urandom);
    roll = $urandom_range(99);
    if (roll < 60)       r.add_amount = 32'($urandom_range(20)) - 32'sd10;
    else if (roll < 80)  r.add_amount = 32'($urandom);
    else if (roll < 88)  r.add_amount = INT_TOP;
    else if (roll < 96)  r.add_amount = INT_BOTTOM;
    else                 r.add_amount = 32'sd0;
    return r;
  endfunction

  // Offers one request, with random idle cycles in front of it, and records what it
  // should produce once it has been taken.  Entered and left just after a rising edge.
  task automatic send_request(request_t r, bit typed, result_t want);
    expected_t e;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      request_valid <= 1'b0;
      @(posedge clk);
    end
    request_valid <= 1'b1;
    request       <= r;
    do @(posedge clk); while (request_stall);
    // Always run the predictor so that its state follows the block even on typed rows.
    e.res = apply_command(r);
    if (typed) e.res = want;
    e.num = item_num;
    item_num++;
    pending_results = {pending_results, e};
  endtask

  // Holds the request side off until every outstanding result has come back.
  task automatic drain_results();
    request_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Each result taken is compared with the oldest outstanding expectation.
  always @(posedge clk) begin : check_results
    expected_t head;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: result_value %0d", result.result_value);
        error_count++;
      end else begin
        head = pending_results.pop_front();
        if (result.result_value !== head.res.result_value) begin
          $error("item %0d result_value: expected %0d, actual %0d",
                 head.num, head.res.result_value, result.result_value);
          error_count++;
        end
        if (result.accepted !== head.res.accepted) begin
          $error("item %0d accepted: expected %0b, actual %0b",
                 head.num, head.res.accepted, result.accepted);
          error_count++;
        end
        if (result.saved_total !== head.res.saved_total) begin
          $error("item %0d saved_total: expected %0d, actual %0d",
                 head.num, head.res.saved_total, result.saved_total);
          error_count++;
        end
        if (result.ignored_total !== head.res.ignored_total) begin
          $error("item %0d ignored_total: expected %0d, actual %0d",
                 head.num, head.res.ignored_total, result.ignored_total);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int       send_idle [4];
    int       recv_stall [4];
    int       p;
    int       i;
    request_t r;
    result_t  none;

    send_idle  = '{0, 76, 0, 29};
    recv_stall = '{0, 0, 76, 29};
    none       = '0;

    // Our copy of the table starts as the block does after its reset pass.
    for (i = 0; i < TABLE_SIZE; i++) begin
      label_copy[i] = IDX_W'(i);
      count_copy[i] = 0;
    end
    iter_pos    = -1;
    saved_cnt   = '0;
    ignored_cnt = '0;

    // Directed rows.  Typed results are the obvious ones: the reset contents, the ends
    // of the index range, saturation at both signed limits and out-of-range adds.
    add_row(CMD_READ_LABEL, 16'd0, 32'sd0, 1, 32'sd0, 1'b1, 32'd0, 32'd0);
    add_row(CMD_READ_LABEL, 16'(TABLE_SIZE - 1), 32'sd0, 1, TABLE_SIZE - 1, 1'b1, 32'd0, 32'd0);
    add_row(CMD_READ_COUNT, 16'(TABLE_SIZE), 32'sd0, 1, 32'sd0, 1'b0, 32'd0, 32'd0);
    add_row(CMD_READ_LABEL, 16'hffff, 32'sd0, 1, 32'sd0, 1'b0, 32'd0, 32'd0);
    add_row(CMD_NEXT, 16'd0, 32'sd0, 1, 32'sd0, 1'b1, 32'd0, 32'd0);
    add_row(CMD_ADD, 16'd0, INT_TOP, 1, 32'sd0, 1'b1, 32'd1, 32'd0);
    add_row(CMD_ADD, 16'd0, INT_TOP, 1, 32'sd0, 1'b1, 32'd2, 32'd0);
    add_row(CMD_READ_COUNT, 16'd0, 32'sd0, 1, INT_TOP, 1'b1, 32'd2, 32'd0);
    add_row(CMD_ADD, 16'd1, INT_BOTTOM, 1, 32'sd0, 1'b1, 32'd3, 32'd0);
    add_row(CMD_ADD, 16'd1, INT_BOTTOM, 1, 32'sd0, 1'b1, 32'd4, 32'd0);
    add_row(CMD_READ_COUNT, 16'd1, 32'sd0, 1, INT_BOTTOM, 1'b1, 32'd4, 32'd0);
    add_row(CMD_ADD, 16'hffff, 32'sd5, 1, 32'sd0, 1'b0, 32'd4, 32'd1);
    add_row(CMD_ADD, 16'(TABLE_SIZE), -32'sd1, 1, 32'sd0, 1'b0, 32'd4, 32'd2);
    // Two equal counts, then a sort: the earlier of the pair must stay in front.
    add_row(CMD_ADD, 16'd7, 32'sd3, 0, '0, 1'b0, '0, '0);
    add_row(CMD_ADD, 16'd9, 32'sd3, 0, '0, 1'b0, '0, '0);
    add_row(CMD_ADD, 16'(TABLE_SIZE - 1), -32'sd7, 0, '0, 1'b0, '0, '0);
    add_row(CMD_SORT, 16'd0, 32'sd0, 0, '0, 1'b0, '0, '0);
    add_row(CMD_READ_LABEL, 16'd0, 32'sd0, 0, '0, 1'b0, '0, '0);
    add_row(CMD_READ_LABEL, 16'd1, 32'sd0, 0, '0, 1'b0, '0, '0);
    add_row(CMD_READ_LABEL, 16'd2, 32'sd0, 0, '0, 1'b0, '0, '0);
    add_row(CMD_READ_LABEL, 16'(TABLE_SIZE - 1), 32'sd0, 0, '0, 1'b0, '0, '0);
    add_row(CMD_NEXT, 16'd0, 32'sd0, 0, '0, 1'b0, '0, '0);
    add_row(CMD_REWIND, 16'd0, 32'sd0, 0, '0, 1'b0, '0, '0);
    add_row(CMD_NEXT, 16'd0, 32'sd0, 0, '0, 1'b0, '0, '0);
    add_row(CMD_CLEAR, 16'd0, 32'sd0, 0, '0, 1'b0, '0, '0);
    add_row(CMD_READ_COUNT, 16'd0, 32'sd0, 0, '0, 1'b0, '0, '0);
    add_row(CMD_UNUSED, 16'd3, -32'sd1, 0, '0, 1'b0, '0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The block runs its own clearing pass after reset and holds request_stall high
    // meanwhile, so the first request simply waits at the handshake.
    foreach (directed_rows[k]) begin
      send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
    end
    drain_results();

    for (p = 0; p < 4; p++) begin
      idle_pct  = send_idle[p];
      stall_pct = recv_stall[p];
      if (p == 0) begin
        // A full walk of the iterator: every label, then a couple of steps past the end.
        r = '0;
        r.command = CMD_REWIND;
        send_request(r, 0, none);
        r.command = CMD_NEXT;
        repeat (TABLE_SIZE + 2) send_request(r, 0, none);
      end
      repeat (PHASE_ITEMS) send_request(random_request(), 0, none);
      // The sender waits here until the block has answered everything.
      drain_results();
    end

    stall_pct = 0;
    repeat (SETTLE_TICKS) @(posedge clk);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/rct_pkg.sv
rtl/rct_controller.sv
rtl/rct_datapath.sv
rtl/ranked_count_table.sv
rtl/rct_checker.sv
verif/tb_ranked_count_table.sv
